FILE: design/page_free_list_allocator_assert.svh
// assertion macros for the allocator port checker
`ifndef PAGE_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define PAGE_FREE_LIST_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define PFLA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pfla check failed");

// next-cycle implication
`define PFLA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pfla check failed");

`endif

FILE: design/pfla_pkg.sv
// shared constants, codes and types of the page free-list allocator
package pfla_pkg;

    localparam int NUM_PAGES  = 4096;
    localparam int PAGE_BYTES = 4096;
    localparam int ADDR_W     = 40;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int IDX_W      = $clog2(NUM_PAGES);
    localparam int CNT_W      = $clog2(NUM_PAGES + 1);
    localparam int LINK_W     = IDX_W + 1;
    localparam int ALU_W      = ADDR_W + 2;
    localparam int PGN_W      = ALU_W - 1 - PAGE_SHIFT;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_INIT  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_BAD     = 2'd2,
        ST_OUTSIDE = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BASE,
        S_SPAN,
        S_ALLOC,
        S_ALLOC_POP,
        S_FREE,
        S_INIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } t_alu_req;

endpackage

FILE: design/pfla_ram.sv
// generic single-port ram with registered read
module pfla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        o_rdata <= mem[i_addr];
    end

endmodule

FILE: design/pfla_alu.sv
// shared adder and subtractor of the allocator sequencer
module pfla_alu (
    input  pfla_pkg::t_alu_req        i_req,
    output logic [pfla_pkg::ALU_W-1:0] o_sum
);
    import pfla_pkg::*;

    logic [ALU_W-1:0] b_eff;

    assign b_eff = i_req.b ^ {ALU_W{i_req.sub}};
    assign o_sum = i_req.a + b_eff + ALU_W'(i_req.sub);

endmodule

FILE: design/page_free_list_allocator.sv
// page free-list allocator top level: sequencer, link ram and output register
//
// Keeps a last-in-first-out list of free pages inside the configured byte range,
// linked through a 4096 x 13 single-port ram. Every beat first uses one shared
// 42-bit adder in S_BASE and S_SPAN to work out the managed base and page count,
// then the op itself runs on that same adder. An alloc that pops a page adds the
// S_ALLOC_POP step (the link ram read is registered), the unused op code goes
// straight to S_DONE, and a rebuild writes one link per cycle. The input stays
// stalled for the whole beat; a result waits in the output register, so a stalled
// consumer only holds the block at the end of a beat. The link ram needs no
// clearing after reset: every entry is written before it is read.
module page_free_list_allocator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_op,
    input  logic [pfla_pkg::ADDR_W-1:0]   i_page_addr,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [pfla_pkg::ADDR_W-1:0]   o_alloc_addr,
    output logic [1:0]                    o_status,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [pfla_pkg::ADDR_W-1:0]   i_cfg_data
);
    import pfla_pkg::*;

    localparam logic CFG_START = 1'b0;
    localparam logic CFG_END   = 1'b1;

    t_state              r_state, n_state;
    t_op                 r_op, n_op;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    logic [ADDR_W-1:0]   r_start, r_end;
    logic [ADDR_W:0]     r_base, n_base;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [IDX_W-1:0]    r_head_index, n_head_index;
    logic                r_head_valid, n_head_valid;
    logic [CNT_W-1:0]    r_k, n_k;
    logic [ADDR_W-1:0]   r_res_addr, n_res_addr;
    t_status             r_res_status, n_res_status;
    logic                r_out_valid, n_out_valid;
    logic [ADDR_W-1:0]   r_out_addr, n_out_addr;
    t_status             r_out_status, n_out_status;

    t_alu_req            alu_req;
    logic [ALU_W-1:0]    alu_sum;
    logic                ram_we;
    logic [IDX_W-1:0]    ram_addr;
    logic [LINK_W-1:0]   ram_wdata;
    logic [LINK_W-1:0]   ram_rdata;
    logic [PGN_W-1:0]    page_num;

    pfla_alu u_alu (
        .i_req (alu_req),
        .o_sum (alu_sum)
    );

    pfla_ram #(
        .WIDTH (LINK_W),
        .DEPTH (NUM_PAGES)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign page_num     = alu_sum[ALU_W-2:PAGE_SHIFT];
    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_alloc_addr = r_out_addr;
    assign o_status     = r_out_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            r_end   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_START: r_start <= i_cfg_data;
                CFG_END:   r_end   <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_head_index <= '0;
            r_head_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_head_index <= n_head_index;
            r_head_valid <= n_head_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_addr       <= n_addr;
        r_base       <= n_base;
        r_count      <= n_count;
        r_k          <= n_k;
        r_res_addr   <= n_res_addr;
        r_res_status <= n_res_status;
        r_out_addr   <= n_out_addr;
        r_out_status <= n_out_status;
    end

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_addr       = r_addr;
        n_base       = r_base;
        n_count      = r_count;
        n_head_index = r_head_index;
        n_head_valid = r_head_valid;
        n_k          = r_k;
        n_res_addr   = r_res_addr;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid;
        n_out_addr   = r_out_addr;
        n_out_status = r_out_status;
        alu_req      = '0;
        ram_we       = 1'b0;
        ram_addr     = r_head_index;
        ram_wdata    = {r_head_valid, r_head_index};

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op    = t_op'(i_op);
                    n_addr  = i_page_addr;
                    n_state = S_BASE;
                end
            end
            S_BASE: begin
                // round range start up to a page boundary
                alu_req.a = {2'b00, r_start[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
                alu_req.b = (r_start[PAGE_SHIFT-1:0] != '0) ? ALU_W'(PAGE_BYTES) : '0;
                n_base    = alu_sum[ADDR_W:0];
                n_state   = S_SPAN;
            end
            S_SPAN: begin
                alu_req.a   = {2'b00, r_end};
                alu_req.b   = {1'b0, r_base};
                alu_req.sub = 1'b1;
                if (alu_sum[ALU_W-1]) begin
                    n_count = '0;
                end else if (page_num >= PGN_W'(NUM_PAGES)) begin
                    n_count = CNT_W'(NUM_PAGES);
                end else begin
                    n_count = page_num[CNT_W-1:0];
                end
                n_res_addr   = '0;
                n_res_status = ST_OK;
                unique case (r_op)
                    OP_ALLOC: n_state = S_ALLOC;
                    OP_FREE:  n_state = S_FREE;
                    OP_INIT: begin
                        n_head_valid = 1'b0;
                        n_head_index = '0;
                        n_k          = '0;
                        n_state      = S_INIT;
                    end
                    OP_NONE:  n_state = S_DONE;
                endcase
            end
            S_ALLOC: begin
                if (!r_head_valid) begin
                    n_res_status = ST_EMPTY;
                    n_state      = S_DONE;
                end else begin
                    alu_req.a  = {1'b0, r_base};
                    alu_req.b  = ALU_W'({r_head_index, {PAGE_SHIFT{1'b0}}});
                    n_res_addr = alu_sum[ADDR_W-1:0];
                    n_state    = S_ALLOC_POP;
                end
            end
            S_ALLOC_POP: begin
                n_head_valid = ram_rdata[IDX_W];
                n_head_index = ram_rdata[IDX_W] ? ram_rdata[IDX_W-1:0] : '0;
                n_state      = S_DONE;
            end
            S_FREE: begin
                alu_req.a   = {2'b00, r_addr};
                alu_req.b   = {1'b0, r_base};
                alu_req.sub = 1'b1;
                n_state     = S_DONE;
                if ((r_addr == '0) || (r_addr[PAGE_SHIFT-1:0] != '0)) begin
                    n_res_status = ST_BAD;
                end else if (alu_sum[ALU_W-1] || (page_num >= PGN_W'(r_count))) begin
                    n_res_status = ST_OUTSIDE;
                end else begin
                    ram_we       = 1'b1;
                    ram_addr     = page_num[IDX_W-1:0];
                    n_head_index = page_num[IDX_W-1:0];
                    n_head_valid = 1'b1;
                end
            end
            S_INIT: begin
                if (r_k == r_count) begin
                    n_state = S_DONE;
                end else begin
                    // push page k onto the list
                    ram_we       = 1'b1;
                    ram_addr     = r_k[IDX_W-1:0];
                    n_head_index = r_k[IDX_W-1:0];
                    n_head_valid = 1'b1;
                    alu_req.a    = ALU_W'(r_k);
                    alu_req.b    = ALU_W'(1);
                    n_k          = alu_sum[CNT_W-1:0];
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_addr   = r_res_addr;
                    n_out_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end
        endcase
    end

endmodule

FILE: design/pfla_checker.sv
// port-level checks on the page free-list allocator, bound to the top level
`include "page_free_list_allocator_assert.svh"

module pfla_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_stall,
    input logic                        i_out_valid,
    input logic                        i_out_stall,
    input logic [pfla_pkg::ADDR_W-1:0] i_alloc_addr,
    input logic [1:0]                  i_status
);
    import pfla_pkg::*;

    logic                out_wait;
    logic                out_fail;
    logic [ADDR_W+1:0]   out_beat;

    assign out_wait = i_out_valid && i_out_stall;
    assign out_fail = i_out_valid && (i_status != ST_OK);
    assign out_beat = {i_alloc_addr, i_status};

    // a held result beat keeps its payload
    `PFLA_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_wait, i_out_valid && $stable(out_beat))

    // failed ops never hand out an address
    `PFLA_ASSERT_NOW(a_fail_no_addr, i_clk, i_rst_n, out_fail, i_alloc_addr == '0)

    // the block is busy straight after taking a beat
    `PFLA_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !i_in_stall, i_in_stall)

    // a new result only appears at the end of a busy spell
    `PFLA_ASSERT_NOW(a_result_from_work, i_clk, i_rst_n, $rose(i_out_valid), $past(i_in_stall))

endmodule

bind page_free_list_allocator pfla_checker u_pfla_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .i_in_stall   (o_in_stall),
    .i_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .i_alloc_addr (o_alloc_addr),
    .i_status     (o_status)
);

FILE: test/pfla_tb_pkg.sv
// register indexes and expected result type shared by the allocator testbench files
package pfla_tb_pkg;

    typedef enum logic {
        REG_RANGE_START = 1'b0,
        REG_RANGE_END   = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [pfla_pkg::ADDR_W-1:0] alloc_addr;
        pfla_pkg::t_status           status;
    } t_page_result;

endpackage

FILE: test/page_free_list_allocator_checker.sv
// checker for the page free-list allocator: mirrors the free list and compares every result beat
module page_free_list_allocator_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic [1:0]                  i_op,
    input  logic [pfla_pkg::ADDR_W-1:0] i_page_addr,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic [pfla_pkg::ADDR_W-1:0] i_alloc_addr,
    input  logic [1:0]                  i_status,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [pfla_pkg::ADDR_W-1:0] i_cfg_data,
    output int                          o_fail_count,
    output int                          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import pfla_pkg::*;
    import pfla_tb_pkg::*;

    logic [ADDR_W-1:0] range_lo;
    logic [ADDR_W-1:0] range_hi;
    logic [IDX_W-1:0]  free_head;
    logic              free_head_vld;
    logic [LINK_W-1:0] next_free [NUM_PAGES];
    t_page_result      results_due [$];
    t_page_result      due;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic longint unsigned managed_base();
        longint unsigned lo;
        lo = 64'(range_lo);
        return ((lo + PAGE_BYTES - 1) / PAGE_BYTES) * PAGE_BYTES;
    endfunction

    function automatic longint unsigned managed_pages(input longint unsigned base);
        longint unsigned hi;
        hi = 64'(range_hi);
        if (hi <= base)
            return 0;
        if ((hi - base) / PAGE_BYTES > NUM_PAGES)
            return NUM_PAGES;
        return (hi - base) / PAGE_BYTES;
    endfunction

    function automatic void push_free(input int unsigned idx);
        next_free[idx] = free_head_vld ? {1'b1, free_head} : '0;
        free_head      = IDX_W'(idx);
        free_head_vld  = 1'b1;
    endfunction

    task automatic predict_page_op(input t_op op, input logic [ADDR_W-1:0] addr);
        longint unsigned   base;
        longint unsigned   pages;
        logic [LINK_W-1:0] link;
        t_page_result      res;
        base           = managed_base();
        pages          = managed_pages(base);
        res.alloc_addr = '0;
        res.status     = ST_OK;
        case (op)
            OP_ALLOC: begin
                if (!free_head_vld) begin
                    res.status = ST_EMPTY;
                end else begin
                    link           = next_free[free_head];
                    res.alloc_addr = ADDR_W'(base + 64'(free_head) * PAGE_BYTES);
                    free_head_vld  = link[IDX_W];
                    free_head      = link[IDX_W] ? link[IDX_W-1:0] : '0;
                end
            end
            OP_FREE: begin
                if (addr == '0 || addr[PAGE_SHIFT-1:0] != '0) begin
                    res.status = ST_BAD;
                end else if (64'(addr) < base || (64'(addr) - base) / PAGE_BYTES >= pages) begin
                    res.status = ST_OUTSIDE;
                end else begin
                    push_free(int'((64'(addr) - base) / PAGE_BYTES));
                end
            end
            OP_INIT: begin
                free_head_vld = 1'b0;
                free_head     = '0;
                for (int k = 0; k < int'(pages); k++)
                    push_free(k);
            end
            default: begin
            end
        endcase
        results_due.push_back(res);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            range_lo      = '0;
            range_hi      = '0;
            free_head     = '0;
            free_head_vld = 1'b0;
            results_due.delete();
        end else begin
            if (i_cfg_we) begin
                if (t_cfg_reg'(i_cfg_index) == REG_RANGE_START)
                    range_lo = i_cfg_data;
                else
                    range_hi = i_cfg_data;
            end
            if (i_out_valid && !i_out_stall) begin
                if (results_due.size() == 0) begin
                    $error("result beat with nothing expected: alloc_addr %h, status %0d",
                           i_alloc_addr, i_status);
                    o_fail_count++;
                end else begin
                    due = results_due.pop_front();
                    if (i_alloc_addr !== due.alloc_addr) begin
                        $error("alloc_addr mismatch: expected %h, got %h",
                               due.alloc_addr, i_alloc_addr);
                        o_fail_count++;
                    end
                    if (i_status !== due.status) begin
                        $error("status mismatch: expected %0d, got %0d", due.status, i_status);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                predict_page_op(t_op'(i_op), i_page_addr);
        end
        o_pending = results_due.size();
    end

endmodule

FILE: test/page_free_list_allocator_tb.sv
// testbench top for the page free-list allocator: clock, reset, stimulus and verdict
module page_free_list_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pfla_pkg::*;
    import pfla_tb_pkg::*;

    localparam int                CYCLE_LIMIT = 1_000_000;
    localparam int                LONG_HOLD   = 300;
    localparam int                NUM_PHASES  = 10;
    localparam int                PHASE_BEATS = 60;
    localparam logic [ADDR_W-1:0] ADDR_MAX    = {ADDR_W{1'b1}};

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_TOGGLE
    } t_stall_mode;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_stall;
    logic [1:0]        i_op        = OP_NONE;
    logic [ADDR_W-1:0] i_page_addr = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [ADDR_W-1:0] o_alloc_addr;
    logic [1:0]        o_status;
    logic              i_cfg_we    = 1'b0;
    logic              i_cfg_index = REG_RANGE_START;
    logic [ADDR_W-1:0] i_cfg_data  = '0;

    int                fail_count;
    int                results_pending;
    bit                hold_out    = 1'b0;
    longint unsigned   cur_base    = 0;
    int                cur_pages   = 0;

    page_free_list_allocator u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_op         (i_op),
        .i_page_addr  (i_page_addr),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_alloc_addr (o_alloc_addr),
        .o_status     (o_status),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    page_free_list_allocator_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_op         (i_op),
        .i_page_addr  (i_page_addr),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_alloc_addr (o_alloc_addr),
        .i_status     (o_status),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (results_pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [ADDR_W-1:0] noise_addr();
        return ADDR_W'({$urandom, $urandom});
    endfunction

    function automatic logic [ADDR_W-1:0] pick_free_addr();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (cur_pages > 0 && pick < 78)
            return ADDR_W'(cur_base + 64'($urandom_range(0, cur_pages - 1)) * PAGE_BYTES);
        if (pick < 84)
            return ADDR_W'(cur_base + 64'(cur_pages + $urandom_range(0, 3)) * PAGE_BYTES);
        if (pick < 88)
            return ADDR_W'(cur_base - 64'($urandom_range(1, 4)) * PAGE_BYTES);
        if (pick < 94)
            return ADDR_W'(cur_base + $urandom_range(1, PAGE_BYTES - 1));
        return noise_addr();
    endfunction

    task automatic send_beat(input t_op op, input logic [ADDR_W-1:0] addr);
        i_in_valid  <= 1'b1;
        i_op        <= op;
        i_page_addr <= addr;
        do
            @(posedge i_clk);
        while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        wait (results_pending == 0);
        @(negedge i_clk);
    endtask

    task automatic set_range(input logic [ADDR_W-1:0] lo, input logic [ADDR_W-1:0] hi);
        longint unsigned base;
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_RANGE_START;
        i_cfg_data  <= lo;
        @(negedge i_clk);
        i_cfg_index <= REG_RANGE_END;
        i_cfg_data  <= hi;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        base     = ((64'(lo) + PAGE_BYTES - 1) / PAGE_BYTES) * PAGE_BYTES;
        cur_base = base;
        if (64'(hi) <= base)
            cur_pages = 0;
        else if ((64'(hi) - base) / PAGE_BYTES > NUM_PAGES)
            cur_pages = NUM_PAGES;
        else
            cur_pages = int'((64'(hi) - base) / PAGE_BYTES);
    endtask

    initial begin
        t_stall_mode mode;
        int          left;
        mode = STALL_NONE;
        left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_out) begin
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_out = 1'b0;
            end
            if (left == 0) begin
                mode = t_stall_mode'($urandom_range(0, 3));
                left = $urandom_range(20, 80);
            end
            left--;
            case (mode)
                STALL_NONE:  i_out_stall <= 1'b0;
                STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
                default:     i_out_stall <= ~i_out_stall;
            endcase
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        logic [ADDR_W-1:0] lo;
        logic [ADDR_W-1:0] hi;
        int                burst_left;
        int                gap;
        int unsigned       pick;
        bit                quiet;
        t_op               op;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty list, zero range
        send_beat(OP_ALLOC, '0);
        send_beat(OP_INIT, ADDR_MAX);
        send_beat(OP_FREE, '0);
        send_beat(OP_FREE, 40'(PAGE_BYTES));
        send_beat(OP_NONE, ADDR_MAX);
        drain();

        // unaligned start rounds up, four pages
        set_range(40'h1800, 40'h2000 + 4 * PAGE_BYTES + 40'h100);
        send_beat(OP_INIT, '0);
        repeat (2) send_beat(OP_ALLOC, '0);
        send_beat(OP_FREE, 40'h2000);
        send_beat(OP_FREE, 40'h2000);
        send_beat(OP_FREE, 40'h2000 + 4 * PAGE_BYTES);
        send_beat(OP_FREE, 40'h1000);
        send_beat(OP_FREE, 40'h2001);
        send_beat(OP_FREE, ADDR_MAX);
        send_beat(OP_FREE, 40'hFF_FFFF_F000);
        repeat (5) send_beat(OP_ALLOC, noise_addr());
        send_beat(OP_NONE, '0);
        drain();

        // whole space, page count capped
        set_range('0, ADDR_MAX);
        send_beat(OP_INIT, '0);
        send_beat(OP_FREE, 40'(NUM_PAGES) * PAGE_BYTES);
        drain();

        // list kept across a base change, address wraps at the top
        set_range(40'hFF_FFFF_F000, ADDR_MAX);
        send_beat(OP_ALLOC, '0);
        drain();
        set_range(ADDR_MAX, ADDR_MAX);
        send_beat(OP_FREE, 40'hFF_FFFF_F000);
        send_beat(OP_ALLOC, '0);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            drain();
            case (phase)
                2: set_range('0, ADDR_MAX);
                6: set_range(40'hFF_FFE0_0000, ADDR_MAX);
                8: begin
                    lo = {8'($urandom_range(1, 254)), 32'($urandom)};
                    set_range(lo, lo - $urandom_range(1, 4 * PAGE_BYTES));
                end
                default: begin
                    lo = {8'($urandom_range(0, 254)), 32'($urandom)};
                    if ($urandom_range(0, 1))
                        lo[PAGE_SHIFT-1:0] = '0;
                    hi = lo + 40'($urandom_range(0, 48)) * PAGE_BYTES
                            + $urandom_range(0, 2 * PAGE_BYTES);
                    set_range(lo, hi);
                end
            endcase
            if ($urandom_range(0, 3) != 0)
                send_beat(OP_INIT, noise_addr());
            quiet      = (phase % 4 == 1);
            burst_left = 0;
            for (int n = 0; n < PHASE_BEATS; n++) begin
                if (phase == 3 && n == 10)
                    hold_out = 1'b1;
                if (!quiet) begin
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 12);
                        gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                        if (gap > 0) begin
                            i_in_valid <= 1'b0;
                            repeat (gap) @(negedge i_clk);
                        end
                    end
                    burst_left--;
                end
                pick = $urandom_range(0, 99);
                if (pick < 46)
                    op = OP_ALLOC;
                else if (pick < 90)
                    op = OP_FREE;
                else if (pick < 95)
                    op = OP_INIT;
                else
                    op = OP_NONE;
                send_beat(op, (op == OP_FREE) ? pick_free_addr() : noise_addr());
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && results_pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
